// ===== design/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types, constants and arithmetic helpers of the channel permute and
// scale unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cps_pkg;

    // Storage depth and derived widths
    localparam int MAX_CHANNELS = 64;
    localparam int CH_W         = 6;
    localparam int CNT_W        = 7;
    localparam int SAMPLE_W     = 16;
    localparam int SCALE_W      = 16;
    localparam int PROD_W       = SAMPLE_W + SCALE_W;

    // Channel count register reset value
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_CHANNELS);
    localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_CHANNELS);
    localparam logic [CNT_W-1:0] COUNT_MIN   = CNT_W'(1);

    // Beat commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Emission sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAB,
        ST_PIX,
        ST_MUL
    } cps_state_t;

    // One permutation table entry
    typedef struct packed {
        logic [CH_W-1:0]           src;
        logic signed [SCALE_W-1:0] scale;
    } tab_entry_t;

    // Table write request
    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
        tab_entry_t      entry;
    } tab_wr_t;

    // Effective channel count: register clamped to 1..MAX_CHANNELS
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] cfg);
        logic [CNT_W-1:0] c;
        c = cfg;
        if (c < COUNT_MIN)
            c = COUNT_MIN;
        if (c > COUNT_MAX)
            c = COUNT_MAX;
        return c;
    endfunction

    // Q12.20 product to Q8.8: round half up, then saturate to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W:0]    biased;
        logic signed [PROD_W-12:0] q;
        logic signed [SAMPLE_W-1:0] r;
        biased = {prod[PROD_W-1], prod} + (PROD_W+1)'(2048);
        q = biased[PROD_W:12];
        if (q > (PROD_W-11)'(32767))
            r = 16'sh7FFF;
        else if (q < -(PROD_W-11)'(32768))
            r = 16'sh8000;
        else
            r = q[SAMPLE_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/cps_item_if.sv =====
// ----------------------------------------------------------------------------
// cps_item_if
// Input channel: table loads and channel samples, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cps_item_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic [cps_pkg::CH_W-1:0]              table_channel;
    logic [cps_pkg::CH_W-1:0]              source_channel;
    logic signed [cps_pkg::SCALE_W-1:0]    scale_value;
    logic signed [cps_pkg::SAMPLE_W-1:0]   sample_value;

    modport source (
        output valid, command, table_channel, source_channel, scale_value, sample_value,
        input  ready
    );

    modport sink (
        input  valid, command, table_channel, source_channel, scale_value, sample_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/cps_result_if.sv =====
// ----------------------------------------------------------------------------
// cps_result_if
// Output channel: scaled gathered samples, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cps_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cps_pkg::SAMPLE_W-1:0]   result_value;
    logic [cps_pkg::CH_W-1:0]              out_channel;
    logic                                  last;

    modport source (
        output valid, result_value, out_channel, last,
        input  ready
    );

    modport sink (
        input  valid, result_value, out_channel, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/cps_table_mem.sv =====
// ----------------------------------------------------------------------------
// cps_table_mem
// Permutation table: source channel and scale per output channel. One write
// and one read port, registered read. Per-entry valid bits make unloaded
// entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_table_mem (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cps_pkg::tab_wr_t             wr,
    input  wire logic                         rd_en,
    input  wire logic [cps_pkg::CH_W-1:0]     rd_addr,
    output cps_pkg::tab_entry_t               rd_data
);

    cps_pkg::tab_entry_t                  mem [cps_pkg::MAX_CHANNELS];
    logic [cps_pkg::MAX_CHANNELS-1:0]     valid_reg;
    cps_pkg::tab_entry_t                  data_reg;
    logic                                 hit_reg;

    // Storage array
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.entry;
        if (rd_en)
            data_reg <= mem[rd_addr];
    end

    // Valid bits and the registered valid of the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en)
                valid_reg[wr.addr] <= 1'b1;
            if (rd_en)
                hit_reg <= valid_reg[rd_addr];
        end
    end

    // Unloaded entries read as zero
    assign rd_data = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

// ===== design/cps_pixel_buf.sv =====
// ----------------------------------------------------------------------------
// cps_pixel_buf
// Sample store for one pixel vector. One write and one read port, registered
// read, no reset of contents.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_pixel_buf (
    input  wire logic                                clk,
    input  wire logic                                wr_en,
    input  wire logic [cps_pkg::CH_W-1:0]            wr_addr,
    input  wire logic signed [cps_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic                                rd_en,
    input  wire logic [cps_pkg::CH_W-1:0]            rd_addr,
    output logic signed [cps_pkg::SAMPLE_W-1:0]      rd_data
);

    logic signed [cps_pkg::SAMPLE_W-1:0] mem [cps_pkg::MAX_CHANNELS];

    // Storage array, read data registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/cps_scale_mult.sv =====
// ----------------------------------------------------------------------------
// cps_scale_mult
// Registered 16x16 signed multiply: Q8.8 sample times Q4.12 scale, exact
// Q12.20 product.
// ----------------------------------------------------------------------------
`default_nettype none

module cps_scale_mult (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic signed [cps_pkg::SAMPLE_W-1:0] sample,
    input  wire logic signed [cps_pkg::SCALE_W-1:0]  scale,
    output logic signed [cps_pkg::PROD_W-1:0]        product_reg
);

    logic signed [cps_pkg::PROD_W-1:0] product_next;

    // Full-width signed product
    assign product_next = cps_pkg::PROD_W'(sample) * cps_pkg::PROD_W'(scale);

    always_ff @(posedge clk)
    begin
        if (en)
            product_reg <= product_next;
    end

endmodule

`default_nettype wire

// ===== design/channel_permute_scale_unit.sv =====
// ----------------------------------------------------------------------------
// channel_permute_scale_unit
// Per-pixel channel shuffle with a per-channel Q4.12 scale on Q8.8 samples.
// ----------------------------------------------------------------------------
// A load beat writes one table entry and a sample beat stores one channel of
// the current pixel. The sample that brings the held count to the effective
// channel count (register clamped to 1..64) starts the emission: for each
// output channel the sequencer reads the table memory, then the pixel buffer
// at the gathered source, then multiplies, and no input beat is accepted
// during the emission. Each result step is set by the two registered memory
// reads and the registered multiplier in series, and a result not yet taken
// at the output holds the sequencer. The last result sits in the output
// register and the next pixel may start filling before it is taken. A source
// channel at or beyond the count gives zero. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_permute_scale_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cps_item_if.sink                         items,
    cps_result_if.source                     results,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cps_pkg::CNT_W-1:0]   cfg_wr_data
);

    // Configuration and control state
    logic [cps_pkg::CNT_W-1:0]           count_reg;
    logic [cps_pkg::CNT_W-1:0]           count_eff;
    logic [cps_pkg::CNT_W-1:0]           fill_reg;
    logic [cps_pkg::CNT_W-1:0]           fill_next;
    logic [cps_pkg::CNT_W-1:0]           fill_inc;
    logic [cps_pkg::CH_W-1:0]            n_reg;
    logic [cps_pkg::CH_W-1:0]            n_next;
    cps_pkg::cps_state_t                 state_reg;
    cps_pkg::cps_state_t                 state_next;

    // Datapath
    cps_pkg::tab_wr_t                    tab_wr;
    cps_pkg::tab_entry_t                 tab_rd_data;
    logic                                tab_rd_en;
    logic [cps_pkg::CH_W-1:0]            tab_rd_addr;
    logic                                pix_wr_en;
    logic                                pix_rd_en;
    logic signed [cps_pkg::SAMPLE_W-1:0] pix_rd_data;
    logic signed [cps_pkg::SCALE_W-1:0]  scale_reg;
    logic                                src_ok_reg;
    logic                                stage_load;
    logic                                mult_en;
    logic signed [cps_pkg::PROD_W-1:0]   product;

    // Output register
    logic                                out_valid_reg;
    logic signed [cps_pkg::SAMPLE_W-1:0] out_value_reg;
    logic [cps_pkg::CH_W-1:0]            out_chan_reg;
    logic                                out_last_reg;
    logic                                out_free;
    logic                                out_load;
    logic                                is_last;

    logic                                item_beat;
    logic                                sample_beat;
    logic                                pixel_done;

    assign count_eff   = cps_pkg::clamp_count(count_reg);
    assign item_beat   = items.valid && items.ready;
    assign sample_beat = item_beat && (items.command == cps_pkg::CMD_SAMPLE);
    assign fill_inc    = fill_reg + cps_pkg::CNT_W'(1);
    assign pixel_done  = fill_inc >= count_eff;
    assign out_free    = !out_valid_reg || results.ready;
    assign is_last     = ({1'b0, n_reg} + cps_pkg::CNT_W'(1)) == count_eff;

    // Table writes from load beats
    always_comb
    begin
        tab_wr.en          = item_beat && (items.command == cps_pkg::CMD_LOAD);
        tab_wr.addr        = items.table_channel;
        tab_wr.entry.src   = items.source_channel;
        tab_wr.entry.scale = items.scale_value;
    end

    assign pix_wr_en = sample_beat;

    cps_table_mem u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tab_wr),
        .rd_en   (tab_rd_en),
        .rd_addr (tab_rd_addr),
        .rd_data (tab_rd_data)
    );

    cps_pixel_buf u_pixel (
        .clk     (clk),
        .wr_en   (pix_wr_en),
        .wr_addr (fill_reg[cps_pkg::CH_W-1:0]),
        .wr_data (items.sample_value),
        .rd_en   (pix_rd_en),
        .rd_addr (tab_rd_data.src),
        .rd_data (pix_rd_data)
    );

    cps_scale_mult u_mult (
        .clk         (clk),
        .en          (mult_en),
        .sample      (pix_rd_data),
        .scale       (scale_reg),
        .product_reg (product)
    );

    // Sequencer: inputs are taken only while idle, which keeps buffer and
    // table reads of an emission clear of any write
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        fill_next   = fill_reg;
        items.ready = 1'b0;
        tab_rd_en   = 1'b0;
        tab_rd_addr = n_reg;
        pix_rd_en   = 1'b0;
        stage_load  = 1'b0;
        mult_en     = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            cps_pkg::ST_IDLE:
            begin
                items.ready = 1'b1;
                if (sample_beat)
                begin
                    if (pixel_done)
                    begin
                        fill_next   = '0;
                        n_next      = '0;
                        tab_rd_en   = 1'b1;
                        tab_rd_addr = '0;
                        state_next  = cps_pkg::ST_TAB;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            cps_pkg::ST_TAB:
            begin
                pix_rd_en  = 1'b1;
                stage_load = 1'b1;
                state_next = cps_pkg::ST_PIX;
            end
            cps_pkg::ST_PIX:
            begin
                mult_en    = 1'b1;
                state_next = cps_pkg::ST_MUL;
            end
            cps_pkg::ST_MUL:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (is_last)
                    begin
                        state_next = cps_pkg::ST_IDLE;
                    end
                    else
                    begin
                        n_next      = n_reg + cps_pkg::CH_W'(1);
                        tab_rd_en   = 1'b1;
                        tab_rd_addr = n_reg + cps_pkg::CH_W'(1);
                        state_next  = cps_pkg::ST_TAB;
                    end
                end
            end
            default:
            begin
                state_next = cps_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cps_pkg::ST_IDLE;
            count_reg     <= cps_pkg::COUNT_RESET;
            fill_reg      <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            n_reg     <= n_next;
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Scale and range flag of the gathered entry
    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            scale_reg  <= tab_rd_data.scale;
            src_ok_reg <= {1'b0, tab_rd_data.src} < count_eff;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= src_ok_reg ? cps_pkg::round_sat(product) : '0;
            out_chan_reg  <= n_reg;
            out_last_reg  <= is_last;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.result_value = out_value_reg;
    assign results.out_channel  = out_chan_reg;
    assign results.last         = out_last_reg;

    // The held sample count never reaches the buffer depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < cps_pkg::COUNT_MAX)
        else $error("fill count out of range");

    // A completing sample starts the emission at output channel zero
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_beat && pixel_done) |=> (state_reg == cps_pkg::ST_TAB && n_reg == '0))
        else $error("emission did not start at channel zero");

    // A stalled result holds the sequencer in the multiply step
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cps_pkg::ST_MUL && out_valid_reg && !results.ready)
        |=> (state_reg == cps_pkg::ST_MUL && $stable(n_reg)))
        else $error("result overwritten while stalled");

    // The final beat of a pixel returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && is_last) |=> (state_reg == cps_pkg::ST_IDLE && results.last))
        else $error("last beat mismatch");

endmodule

`default_nettype wire
